/* rtl/pps_pkg.sv */
// Shared types and constants of the preemptive priority scheduler.
`timescale 1ns / 1ps

package pps_pkg;

  // Item opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_req;
  } pps_in_t;

  // Result item
  typedef struct packed {
    logic [3:0]  running_slot;
    logic        idle;
    logic [31:0] tick_time;
    logic        switched;
    logic        first_run;
    logic [31:0] response_time;
    logic        finished;
    logic [31:0] completion_time;
    logic [31:0] turnaround_time;
    logic [31:0] waiting_time;
    logic        all_done;
  } pps_out_t;

  // One process table entry as held in the memory
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } pps_entry_t;

  // Control of the compare unit
  typedef struct packed {
    logic clear;   // drop the current best when an item is accepted
    logic check;   // read data holds an entry to compare this cycle
    logic busy;    // that entry is loaded and has work left
    logic sense;   // 1: higher number wins
  } pps_pick_ctl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH,
    ST_DONE
  } pps_state_t;

endpackage

/* rtl/pps_ifs.sv */
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps

interface pps_in_if import pps_pkg::*; ();
  logic    valid;
  logic    ready;
  pps_in_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pps_out_if import pps_pkg::*; ();
  logic     valid;
  logic     ready;
  pps_out_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* rtl/pps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pps_pick.sv */
// Compare unit: keeps the best ready entry seen so far during a table scan.
`timescale 1ns / 1ps

module pps_pick import pps_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pps_pick_ctl_t ctl,
  input  logic [IDX_W-1:0] idx,
  input  pps_entry_t    ent,
  input  logic [31:0]   now,
  output logic          found,
  output logic [IDX_W-1:0] best_idx,
  output pps_entry_t    best_ent
);

  logic             found_r;
  logic [IDX_W-1:0] best_idx_r;
  pps_entry_t       best_ent_r;
  logic             ready_ent;
  logic             wins;

  // Entry is a candidate when loaded, with work left, and already arrived
  assign ready_ent = ctl.check && ctl.busy && ({16'd0, ent.arrival} <= now);

  // Better priority wins; equal priority goes to earlier arrival, else keep the older
  always_comb begin
    if (ent.prio != best_ent_r.prio) begin
      wins = ctl.sense ? (ent.prio > best_ent_r.prio) : (ent.prio < best_ent_r.prio);
    end else begin
      wins = (ent.arrival < best_ent_r.arrival);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (ready_ent) begin
      found_r <= 1'b1;
    end
  end

  // Hold the winner's index and record
  always_ff @(posedge clk) begin
    if (!ctl.clear && ready_ent && (!found_r || wins)) begin
      best_idx_r <= idx;
      best_ent_r <= ent;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best_ent = best_ent_r;

endmodule

/* rtl/preemptive_priority_scheduler_core.sv */
// Preemptive priority scheduler: process table, tick sequencer and result register.
`timescale 1ns / 1ps

// Takes one item at a time. A load, restart or unused opcode goes from acceptance
// straight to the result register, then the block takes the next item. A tick
// first scans the process table: the table sits in one memory with a single read
// port, and the tick walks it one entry per cycle through one compare unit, then
// writes back the chosen entry, computes the turnaround time and fills the result
// register, in that order. Results wait in an output register; a new result that
// finds it still full is held back until the sink takes the previous item. The
// priority sense register may be written only while the block is idle.

module preemptive_priority_scheduler_core import pps_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  pps_in_if.sink   in_ch,
  pps_out_if.source out_ch,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  pps_state_t       state_r, state_nxt;
  logic             sense_r;
  logic [31:0]      time_r;
  logic [31:0]      tt_r;
  logic             prev_valid_r;
  logic [IDX_W-1:0] prev_idx_r;
  logic [SLOTS-1:0] busy_r;
  logic [SLOTS-1:0] started_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             pend_r;
  logic             kind_r;
  logic             served_r;
  logic             switched_r;
  logic             first_r;
  logic             fin_r;
  logic [31:0]      resp_r;
  logic [31:0]      tat_r;
  logic             out_valid_r;
  pps_out_t         out_item_r;
  pps_out_t         out_item_nxt;

  logic             in_acc;
  logic             slot_ok;
  logic [IDX_W-1:0] load_idx;
  logic             load_busy;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  pps_entry_t       ram_wdata;
  pps_entry_t       ram_rdata;
  pps_pick_ctl_t    pick_ctl;
  logic             found;
  logic [IDX_W-1:0] best_idx;
  pps_entry_t       best_ent;
  logic [15:0]      rem_dec;
  logic             out_free;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_ok   = ({28'd0, in_ch.item.slot} < 32'(SLOTS));
  assign load_idx  = IDX_W'(in_ch.item.slot);
  assign load_busy = (in_ch.item.burst_length != 16'd0);
  assign rem_dec   = best_ent.remaining - 16'd1;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Process table memory
  pps_ram #(
    .WIDTH ($bits(pps_entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  // Compare unit
  assign pick_ctl.clear = in_acc;
  assign pick_ctl.check = pend_r;
  assign pick_ctl.busy  = busy_r[cmp_idx_r];
  assign pick_ctl.sense = sense_r;

  pps_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pick_ctl),
    .idx      (cmp_idx_r),
    .ent      (ram_rdata),
    .now      (time_r),
    .found    (found),
    .best_idx (best_idx),
    .best_ent (best_ent)
  );

  // Next state and memory writes
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = load_idx;
    ram_wdata = '{arrival:   in_ch.item.arrival_time,
                  burst:     in_ch.item.burst_length,
                  remaining: in_ch.item.burst_length,
                  prio:      in_ch.item.priority_req};
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.item.op == OP_TICK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
          ram_we = (in_ch.item.op == OP_LOAD) && slot_ok;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_we    = found;
        ram_waddr = best_idx;
        ram_wdata = best_ent;
        ram_wdata.remaining = rem_dec;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sense_r      <= 1'b0;
      time_r       <= '0;
      prev_valid_r <= 1'b0;
      busy_r       <= '0;
      started_r    <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN);
      if (cfg_we) begin
        sense_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          scan_idx_r <= '0;
          if (in_acc && (in_ch.item.op == OP_LOAD) && slot_ok) begin
            // Replace the slot; keep the count of slots with work in step
            busy_r[load_idx]    <= load_busy;
            started_r[load_idx] <= 1'b0;
            if (busy_r[load_idx] && !load_busy) begin
              count_r <= count_r - CNT_W'(1);
            end else if (!busy_r[load_idx] && load_busy) begin
              count_r <= count_r + CNT_W'(1);
            end
          end else if (in_acc && (in_ch.item.op == OP_RESTART)) begin
            busy_r       <= '0;
            started_r    <= '0;
            count_r      <= '0;
            time_r       <= '0;
            prev_valid_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_idx_r != IDX_W'(SLOTS - 1)) begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end
        end
        ST_UPDATE: begin
          time_r       <= time_r + 32'd1;
          prev_valid_r <= found;
          if (found) begin
            started_r[best_idx] <= 1'b1;
            if (rem_dec == 16'd0) begin
              busy_r[best_idx] <= 1'b0;
              count_r          <= count_r - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Per-tick working values
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      cmp_idx_r <= scan_idx_r;
    end
    if (in_acc) begin
      kind_r <= (in_ch.item.op == OP_TICK);
      tt_r   <= time_r;
    end
    if (state_r == ST_UPDATE) begin
      served_r   <= found;
      switched_r <= !prev_valid_r || (prev_idx_r != best_idx);
      first_r    <= !started_r[best_idx];
      fin_r      <= (rem_dec == 16'd0);
      resp_r     <= time_r - {16'd0, best_ent.arrival};
      prev_idx_r <= best_idx;
    end
    if (state_r == ST_FINISH) begin
      // time_r now holds the completion time
      tat_r <= time_r - {16'd0, best_ent.arrival};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Assemble the result item
  always_comb begin
    out_item_nxt          = '0;
    out_item_nxt.idle     = !(kind_r && served_r);
    out_item_nxt.all_done = (count_r == '0);
    if (kind_r) begin
      out_item_nxt.tick_time = tt_r;
    end
    if (kind_r && served_r) begin
      out_item_nxt.running_slot  = 4'(best_idx);
      out_item_nxt.switched      = switched_r;
      out_item_nxt.first_run     = first_r;
      out_item_nxt.response_time = first_r ? resp_r : 32'd0;
      out_item_nxt.finished      = fin_r;
      if (fin_r) begin
        out_item_nxt.completion_time = time_r;
        out_item_nxt.turnaround_time = tat_r;
        out_item_nxt.waiting_time    = tat_r - {16'd0, best_ent.burst};
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

endmodule

/* rtl/pps_chk.sv */
// Port-level checker for the scheduler core, bound into the core module.
`timescale 1ns / 1ps

module pps_chk import pps_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pps_out_t out_item
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One item at a time: after an accept the input closes
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in work");

  // An idle result carries no served-slot information
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.idle) |->
      (out_item.running_slot == 4'd0) && !out_item.switched &&
      !out_item.first_run && !out_item.finished)
    else $error("idle result carries served-slot fields");

  // Completion fields stay zero unless the slot finished
  a_fin_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.finished) |->
      (out_item.completion_time == 32'd0) && (out_item.turnaround_time == 32'd0) &&
      (out_item.waiting_time == 32'd0))
    else $error("completion fields set without finish");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind preemptive_priority_scheduler_core pps_chk u_pps_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);
